@@ hdl/joint_angle_from_three_points_defines.svh @@
// Assertion macros shared by the joint angle checker.
`ifndef JOINT_ANGLE_FROM_THREE_POINTS_DEFINES_SVH
`define JOINT_ANGLE_FROM_THREE_POINTS_DEFINES_SVH

// Clocked assertion, off during reset.
`define JAFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset too.
`define JAFP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/jafp_pkg.sv @@
// Types, constants and tables of the joint angle block.
package jafp_pkg;

  localparam int CW    = 16;  // coordinate width
  localparam int VW    = 16;  // visibility width
  localparam int AW    = 17;  // arm component width
  localparam int PW    = 34;  // product width
  localparam int SW    = 35;  // dot / cross / length width
  localparam int LIMW  = 30;  // squared arm limit width
  localparam int NW    = 40;  // normalized vector width
  localparam int XW    = 43;  // CORDIC x / y width
  localparam int ZW    = 25;  // CORDIC angle width, 2^-16 degree
  localparam int ANGW  = 15;
  localparam int TAGW  = 3;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;
  localparam int ARMW  = 15;

  localparam logic [CFG_IW-1:0] CFG_MIN_VIS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MIN_ARM = 2'd1;

  localparam logic [VW-1:0]   MIN_VIS_RST = 16'd22938;
  localparam logic [ARMW-1:0] MIN_ARM_RST = 15'd492;

  localparam logic [ANGW-1:0]        ANGLE_MAX_OUT = 15'd23040;
  localparam logic signed [ZW-1:0]   DEG90_FINE    = 25'sd5898240;

  localparam int TABLE_LEN = 24;
  localparam int ATAN_FINE [TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_UNSEEN = 2'd1,
    ST_SHORT  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] end_a_x;
    logic signed [CW-1:0] end_a_y;
    logic signed [CW-1:0] vertex_x;
    logic signed [CW-1:0] vertex_y;
    logic signed [CW-1:0] end_b_x;
    logic signed [CW-1:0] end_b_y;
    logic [VW-1:0]        end_a_visibility;
    logic [VW-1:0]        vertex_visibility;
    logic [VW-1:0]        end_b_visibility;
    logic                 supplement;
    logic [TAGW-1:0]      joint_tag;
  } item_t;

  typedef struct packed {
    logic            supplement;
    logic [TAGW-1:0] tag;
    status_t         status;
  } ctl_t;

  typedef struct packed {
    logic signed [AW-1:0] v1x;
    logic signed [AW-1:0] v1y;
    logic signed [AW-1:0] v2x;
    logic signed [AW-1:0] v2y;
    logic                 vis_ok;
    logic                 supplement;
    logic [TAGW-1:0]      tag;
  } diff_t;

  typedef struct packed {
    logic signed [PW-1:0] sq1x;
    logic signed [PW-1:0] sq1y;
    logic signed [PW-1:0] sq2x;
    logic signed [PW-1:0] sq2y;
    logic signed [PW-1:0] dxx;
    logic signed [PW-1:0] dyy;
    logic signed [PW-1:0] cxy;
    logic signed [PW-1:0] cyx;
    logic                 vis_ok;
    logic                 supplement;
    logic [TAGW-1:0]      tag;
  } prod_t;

  typedef struct packed {
    logic signed [SW-1:0] dot;
    logic signed [SW-1:0] crs;
    ctl_t                 ctl;
  } arm_t;

  typedef struct packed {
    logic [NW-1:0] ux;
    logic [NW-1:0] uy;
    logic [NW-1:0] mx;
    logic          dot_neg;
    logic          crs_zero;
    ctl_t          ctl;
  } nrm_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic                 dot_neg;
    logic                 crs_zero;
    ctl_t                 ctl;
  } vec_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 dot_neg;
    logic                 crs_zero;
    ctl_t                 ctl;
  } rot_t;

  typedef struct packed {
    logic [ANGW-1:0] angle;
    ctl_t            ctl;
  } fin_t;

  typedef struct packed {
    logic [ANGW-1:0] angle;
    status_t         status;
    logic [TAGW-1:0] tag;
  } res_t;

endpackage

@@ hdl/jafp_ifs.sv @@
// Channel interfaces: landmark input, angle result and register write.
interface jafp_in_if import jafp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] end_a_x;
  logic signed [CW-1:0] end_a_y;
  logic signed [CW-1:0] vertex_x;
  logic signed [CW-1:0] vertex_y;
  logic signed [CW-1:0] end_b_x;
  logic signed [CW-1:0] end_b_y;
  logic [VW-1:0]        end_a_visibility;
  logic [VW-1:0]        vertex_visibility;
  logic [VW-1:0]        end_b_visibility;
  logic                 supplement;
  logic [TAGW-1:0]      joint_tag;

  modport source (
    output valid, end_a_x, end_a_y, vertex_x, vertex_y, end_b_x, end_b_y,
           end_a_visibility, vertex_visibility, end_b_visibility, supplement, joint_tag,
    input  ready
  );
  modport sink (
    input  valid, end_a_x, end_a_y, vertex_x, vertex_y, end_b_x, end_b_y,
           end_a_visibility, vertex_visibility, end_b_visibility, supplement, joint_tag,
    output ready
  );
endinterface

interface jafp_out_if import jafp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ANGW-1:0] angle;
  logic [1:0]      status;
  logic [TAGW-1:0] joint_tag_out;

  modport source (output valid, angle, status, joint_tag_out, input ready);
  modport sink (input valid, angle, status, joint_tag_out, output ready);
endinterface

interface jafp_cfg_if import jafp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/jafp_front.sv @@
// Arm vectors, visibility test, products, dot / cross and arm length test.
module jafp_front import jafp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  item_t           in_data,
  input  logic [VW-1:0]   vis_threshold,
  input  logic [LIMW-1:0] arm_limit,
  output logic            out_valid,
  input  logic            out_ready,
  output arm_t            out_data
);

  diff_t s1_nxt, s1_r;
  prod_t s2_nxt, s2_r;
  arm_t  s3_nxt, s3_r;
  logic  v1_r, v2_r, v3_r;
  logic  rdy1, rdy2, rdy3;
  logic signed [SW-1:0] len1, len2, lim_s;
  logic                 short_arm;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s1_nxt.v1x = AW'(in_data.end_a_x) - AW'(in_data.vertex_x);
    s1_nxt.v1y = AW'(in_data.end_a_y) - AW'(in_data.vertex_y);
    s1_nxt.v2x = AW'(in_data.end_b_x) - AW'(in_data.vertex_x);
    s1_nxt.v2y = AW'(in_data.end_b_y) - AW'(in_data.vertex_y);
    s1_nxt.vis_ok = (in_data.end_a_visibility >= vis_threshold) &&
                    (in_data.vertex_visibility >= vis_threshold) &&
                    (in_data.end_b_visibility >= vis_threshold);
    s1_nxt.supplement = in_data.supplement;
    s1_nxt.tag        = in_data.joint_tag;
  end

  always_comb begin
    s2_nxt.sq1x = PW'(s1_r.v1x) * PW'(s1_r.v1x);
    s2_nxt.sq1y = PW'(s1_r.v1y) * PW'(s1_r.v1y);
    s2_nxt.sq2x = PW'(s1_r.v2x) * PW'(s1_r.v2x);
    s2_nxt.sq2y = PW'(s1_r.v2y) * PW'(s1_r.v2y);
    s2_nxt.dxx  = PW'(s1_r.v1x) * PW'(s1_r.v2x);
    s2_nxt.dyy  = PW'(s1_r.v1y) * PW'(s1_r.v2y);
    s2_nxt.cxy  = PW'(s1_r.v1x) * PW'(s1_r.v2y);
    s2_nxt.cyx  = PW'(s1_r.v1y) * PW'(s1_r.v2x);
    s2_nxt.vis_ok     = s1_r.vis_ok;
    s2_nxt.supplement = s1_r.supplement;
    s2_nxt.tag        = s1_r.tag;
  end

  assign lim_s = SW'($signed({1'b0, arm_limit}));

  always_comb begin
    len1      = SW'(s2_r.sq1x) + SW'(s2_r.sq1y);
    len2      = SW'(s2_r.sq2x) + SW'(s2_r.sq2y);
    short_arm = (len1 < lim_s) || (len2 < lim_s);
    s3_nxt.dot = SW'(s2_r.dxx) + SW'(s2_r.dyy);
    s3_nxt.crs = SW'(s2_r.cxy) - SW'(s2_r.cyx);
    s3_nxt.ctl.supplement = s2_r.supplement;
    s3_nxt.ctl.tag        = s2_r.tag;
    priority if (!s2_r.vis_ok) begin
      s3_nxt.ctl.status = ST_UNSEEN;
    end else if (short_arm) begin
      s3_nxt.ctl.status = ST_SHORT;
    end else begin
      s3_nxt.ctl.status = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

@@ hdl/jafp_norm.sv @@
// Quadrant pre-rotation and normalizing shift of the (dot, cross) vector.
module jafp_norm import jafp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  arm_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output vec_t out_data
);

  nrm_t sa_nxt, sa_r, sb_nxt, sb_r, sc;
  vec_t sc_nxt, sc_r;
  logic va_r, vb_r, vc_r;
  logic rdya, rdyb, rdyc;
  logic signed [SW-1:0] cabs, dneg, dabs;

  assign rdyc     = !vc_r || out_ready;
  assign rdyb     = !vb_r || rdyc;
  assign rdya     = !va_r || rdyb;
  assign in_ready = rdya;

  always_comb begin
    cabs = in_data.crs[SW-1] ? -in_data.crs : in_data.crs;
    dneg = -in_data.dot;
    dabs = in_data.dot[SW-1] ? dneg : in_data.dot;
    sa_nxt.dot_neg  = in_data.dot[SW-1];
    sa_nxt.crs_zero = (in_data.crs == '0);
    sa_nxt.ux  = in_data.dot[SW-1] ? NW'($unsigned(cabs)) : NW'($unsigned(in_data.dot));
    sa_nxt.uy  = in_data.dot[SW-1] ? NW'($unsigned(dneg)) : NW'($unsigned(cabs));
    sa_nxt.mx  = (cabs > dabs) ? NW'($unsigned(cabs)) : NW'($unsigned(dabs));
    sa_nxt.ctl = in_data.ctl;
  end

  always_comb begin
    sb_nxt = sa_r;
    if (sb_nxt.mx[NW-1:NW-32] == '0) begin
      sb_nxt.mx = sb_nxt.mx << 32;
      sb_nxt.ux = sb_nxt.ux << 32;
      sb_nxt.uy = sb_nxt.uy << 32;
    end
    if (sb_nxt.mx[NW-1:NW-16] == '0) begin
      sb_nxt.mx = sb_nxt.mx << 16;
      sb_nxt.ux = sb_nxt.ux << 16;
      sb_nxt.uy = sb_nxt.uy << 16;
    end
  end

  always_comb begin
    sc = sb_r;
    if (sc.mx[NW-1:NW-8] == '0) begin
      sc.mx = sc.mx << 8;
      sc.ux = sc.ux << 8;
      sc.uy = sc.uy << 8;
    end
    if (sc.mx[NW-1:NW-4] == '0) begin
      sc.mx = sc.mx << 4;
      sc.ux = sc.ux << 4;
      sc.uy = sc.uy << 4;
    end
    if (sc.mx[NW-1:NW-2] == '0) begin
      sc.mx = sc.mx << 2;
      sc.ux = sc.ux << 2;
      sc.uy = sc.uy << 2;
    end
    if (!sc.mx[NW-1]) begin
      sc.mx = sc.mx << 1;
      sc.ux = sc.ux << 1;
      sc.uy = sc.uy << 1;
    end
    sc_nxt.x        = XW'($signed({1'b0, sc.ux}));
    sc_nxt.y        = XW'($signed({1'b0, sc.uy}));
    sc_nxt.dot_neg  = sc.dot_neg;
    sc_nxt.crs_zero = sc.crs_zero;
    sc_nxt.ctl      = sc.ctl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdya) va_r <= in_valid;
      if (rdyb) vb_r <= va_r;
      if (rdyc) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdya) sa_r <= sa_nxt;
    if (rdyb) sb_r <= sb_nxt;
    if (rdyc) sc_r <= sc_nxt;
  end

  assign out_valid = vc_r;
  assign out_data  = sc_r;

endmodule

@@ hdl/jafp_cordic.sv @@
// Vectoring CORDIC, one micro-rotation per pipeline stage.
module jafp_cordic import jafp_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  vec_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rot_t out_data
);

  localparam int N = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;

  rot_t       start;
  rot_t       st_r [1:N];
  logic [N:1] v_r;
  logic [N-1:0] vin;
  logic [N:0] rdy;

  always_comb begin
    start.x        = in_data.x;
    start.y        = in_data.y;
    start.z        = in_data.dot_neg ? DEG90_FINE : '0;
    start.dot_neg  = in_data.dot_neg;
    start.crs_zero = in_data.crs_zero;
    start.ctl      = in_data.ctl;
  end

  assign vin      = {v_r[N-1:1], in_valid};
  assign rdy[N]   = out_ready;
  assign in_ready = rdy[0];

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_FINE[i]);
    rot_t cur, nxt;

    if (i == 0) begin : g_first
      assign cur = start;
    end else begin : g_rest
      assign cur = st_r[i];
    end

    assign rdy[i] = !v_r[i+1] || rdy[i+1];

    always_comb begin
      nxt = cur;
      if (!cur.y[XW-1]) begin
        nxt.x = cur.x + (cur.y >>> i);
        nxt.y = cur.y - (cur.x >>> i);
        nxt.z = cur.z + ATAN_I;
      end else begin
        nxt.x = cur.x - (cur.y >>> i);
        nxt.y = cur.y + (cur.x >>> i);
        nxt.z = cur.z - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i+1] <= vin[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) st_r[i+1] <= nxt;
    end
  end

  assign out_valid = v_r[N];
  assign out_data  = st_r[N];

endmodule

@@ hdl/jafp_finish.sv @@
// Rounding, clamping, special cases, supplement and the output register.
module jafp_finish import jafp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  rot_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  localparam logic [ZW-1:0] RND_BIAS = ZW'(256);

  fin_t f1_nxt, f1_r;
  res_t f2_nxt, f2_r;
  logic v1_r, v2_r;
  logic rdy1, rdy2;
  logic [ZW-2:0] pos;
  logic [ZW-1:0] rsum;
  logic [15:0]   rnd;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    pos  = in_data.z[ZW-1] ? '0 : in_data.z[ZW-2:0];
    rsum = {1'b0, pos} + RND_BIAS;
    rnd  = rsum[ZW-1:9];
    if (in_data.crs_zero) begin
      f1_nxt.angle = in_data.dot_neg ? ANGLE_MAX_OUT : '0;
    end else if (rnd > 16'(ANGLE_MAX_OUT)) begin
      f1_nxt.angle = ANGLE_MAX_OUT;
    end else begin
      f1_nxt.angle = rnd[ANGW-1:0];
    end
    f1_nxt.ctl = in_data.ctl;
  end

  always_comb begin
    if (f1_r.ctl.status != ST_VALID) begin
      f2_nxt.angle = '0;
    end else if (f1_r.ctl.supplement) begin
      f2_nxt.angle = ANGLE_MAX_OUT - f1_r.angle;
    end else begin
      f2_nxt.angle = f1_r.angle;
    end
    f2_nxt.status = f1_r.ctl.status;
    f2_nxt.tag    = f1_r.ctl.tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) f1_r <= f1_nxt;
    if (rdy2) f2_r <= f2_nxt;
  end

  assign out_valid = v2_r;
  assign out_data  = f2_r;

endmodule

@@ hdl/joint_angle_from_three_points.sv @@
// Top level of the joint angle block: registers and pipeline assembly.
//
// in_ch carries one landmark triple per transaction (end point a, vertex,
// end point b, their visibilities, a supplement flag and a joint tag).
// out_ch returns one result per input: angle in 1/128 degree, status
// (valid, point not visible, arm too short) and the joint tag.
// cfg_ch writes the visibility threshold (index 0) and min_arm_length
// (index 1); it is always ready. Write it only while the pipeline is empty.
// Throughput: one transaction per cycle while out_ch is not stalled. The
// pipeline is built from three front stages (differences, multipliers,
// sums), three normalizing stages, one stage per CORDIC iteration and two
// finishing stages.
// Reset empties the pipeline and loads the default thresholds.
// Every stage has its own valid bit and advances when the stage after it
// is free, so a stalled receiver holds the output register and the
// pipeline fills its bubbles before in_ch.ready drops.
module joint_angle_from_three_points import jafp_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  jafp_in_if.sink       in_ch,
  jafp_out_if.source    out_ch,
  jafp_cfg_if.sink      cfg_ch
);

  logic [VW-1:0]   min_vis_r;
  logic [ARMW-1:0] min_arm_r;
  logic [LIMW-1:0] lim_r;

  item_t item;
  arm_t  arm;
  vec_t  vec;
  rot_t  rot;
  res_t  res;
  logic  arm_valid, arm_ready, vec_valid, vec_ready, rot_valid, rot_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_vis_r <= MIN_VIS_RST;
      min_arm_r <= MIN_ARM_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MIN_VIS: min_vis_r <= cfg_ch.data;
        CFG_MIN_ARM: min_arm_r <= cfg_ch.data[ARMW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim_r <= LIMW'(min_arm_r) * LIMW'(min_arm_r);
  end

  always_comb begin
    item.end_a_x           = in_ch.end_a_x;
    item.end_a_y           = in_ch.end_a_y;
    item.vertex_x          = in_ch.vertex_x;
    item.vertex_y          = in_ch.vertex_y;
    item.end_b_x           = in_ch.end_b_x;
    item.end_b_y           = in_ch.end_b_y;
    item.end_a_visibility  = in_ch.end_a_visibility;
    item.vertex_visibility = in_ch.vertex_visibility;
    item.end_b_visibility  = in_ch.end_b_visibility;
    item.supplement        = in_ch.supplement;
    item.joint_tag         = in_ch.joint_tag;
  end

  jafp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (item),
    .vis_threshold (min_vis_r),
    .arm_limit     (lim_r),
    .out_valid     (arm_valid),
    .out_ready     (arm_ready),
    .out_data      (arm)
  );

  jafp_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (arm_valid),
    .in_ready  (arm_ready),
    .in_data   (arm),
    .out_valid (vec_valid),
    .out_ready (vec_ready),
    .out_data  (vec)
  );

  jafp_cordic #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vec_valid),
    .in_ready  (vec_ready),
    .in_data   (vec),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_data  (rot)
  );

  jafp_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_data   (rot),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res)
  );

  assign out_ch.angle         = res.angle;
  assign out_ch.status        = res.status;
  assign out_ch.joint_tag_out = res.tag;

endmodule

@@ hdl/jafp_checker.sv @@
// Port-level checks of the joint angle block and their bind.
`include "joint_angle_from_three_points_defines.svh"

module jafp_checker import jafp_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ANGW-1:0] out_angle,
  input logic [1:0]      out_status
);

  `JAFP_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")
  `JAFP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_angle), "stalled result changed")
  `JAFP_ASSERT(a_reject_zero, out_valid && out_status != ST_VALID |-> out_angle == '0, "rejected item has nonzero angle")
  `JAFP_ASSERT(a_angle_range, out_valid |-> out_angle <= ANGLE_MAX_OUT, "angle above 180 degrees")
  `JAFP_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind joint_angle_from_three_points jafp_checker u_jafp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_angle  (out_ch.angle),
  .out_status (out_ch.status)
);
